/* rtl/core/arbc_pkg.sv */
// Shared types, constants and reset values for the averaged RGB box classifier.
package arbc_pkg;

    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned SUM_W       = 21;
    localparam int unsigned CODE_W      = 3;
    localparam int unsigned BOX_W       = 48;
    localparam int unsigned BOX_COUNT   = 4;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam int unsigned SAMPLES_PER_RUN_DEF = 30;
    localparam int unsigned NUM_CLASSES_DEF     = 4;

    // Reciprocal scale: exact floor quotient for any SUM_W-bit dividend and divisor up to 32
    localparam int unsigned RECIP_SHIFT = SUM_W + 5;

    localparam logic [CODE_W-1:0] CODE_NO_MATCH = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLASS0_BOX = 3'd0,
        REG_CLASS1_BOX = 3'd1,
        REG_CLASS2_BOX = 3'd2,
        REG_CLASS3_BOX = 3'd3
    } t_cfg_reg;

    typedef logic [BOX_W-1:0] t_box;

    localparam t_box BOX_RESET [BOX_COUNT] = '{
        48'd154385964757850,
        48'd99194792898720,
        48'd154427905520790,
        48'd132351099558455
    };

    typedef struct packed {
        logic [PERIOD_W-1:0] red_period;
        logic [PERIOD_W-1:0] green_period;
        logic [PERIOD_W-1:0] blue_period;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]   class_code;
        logic [PERIOD_W-1:0] red_mean;
        logic [PERIOD_W-1:0] green_mean;
        logic [PERIOD_W-1:0] blue_mean;
    } t_out_item;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

    typedef struct packed {
        logic [PERIOD_W-1:0] red;
        logic [PERIOD_W-1:0] green;
        logic [PERIOD_W-1:0] blue;
    } t_means;

endpackage

/* rtl/core/averaged_rgb_box_classifier_top.sv */
// Top level of the averaged RGB box classifier: class box registers and the three-stage path.
//
// Averaged RGB box classifier. Each input item is one red, green and blue
// period sample; the block sums each channel over SAMPLES_PER_RUN items and,
// on the item that closes a run, emits one result item: the floor mean of
// each channel and the first class box (0 up to NUM_CLASSES-1) whose
// inclusive min/max bounds hold all three means, or code 4 when none does.
// Other items produce no result. One input item is accepted every cycle;
// the only stall is on the closing item of a run while the previous run's
// sums still sit in the first stage. The path is three registers deep:
// accumulate and capture the sums, multiply by a constant reciprocal of the
// run length (exact floor for any 21-bit sum), then compare against the
// boxes and register the result. Each box register packs, from the low byte
// up: min red, max red, min green, max green, min blue, max blue. Write
// boxes only while the block is idle; writes to an index with no box are
// dropped, and the config port never stalls.
module averaged_rgb_box_classifier_top #(
    parameter int unsigned SAMPLES_PER_RUN = arbc_pkg::SAMPLES_PER_RUN_DEF,
    parameter int unsigned NUM_CLASSES     = arbc_pkg::NUM_CLASSES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  arbc_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output arbc_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [arbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [arbc_pkg::BOX_W-1:0]         i_cfg_data
);
    import arbc_pkg::*;

    t_box                 r_box [NUM_CLASSES];
    logic [BOX_COUNT-1:0] w_cfg_we;

    logic   w_sum_valid;
    logic   w_sum_ready;
    t_sums  w_sums;
    logic   w_mean_valid;
    logic   w_mean_ready;
    t_means w_means;

    // Config port takes a write every cycle
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cfg_we = '0;
        unique case (i_cfg_idx)
            REG_CLASS0_BOX: w_cfg_we[0] = 1'b1;
            REG_CLASS1_BOX: w_cfg_we[1] = 1'b1;
            REG_CLASS2_BOX: w_cfg_we[2] = 1'b1;
            REG_CLASS3_BOX: w_cfg_we[3] = 1'b1;
            default:        w_cfg_we    = '0;
        endcase
    end

    // Hold one box per configured class; writes to a missing class drop out here
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_box
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_box[g] <= BOX_RESET[g];
            end else if (i_cfg_valid && w_cfg_we[g]) begin
                r_box[g] <= i_cfg_data;
            end
        end
    end

    // Stage 1: accumulate, capture the run's sums on its closing item
    arbc_accum #(
        .SAMPLES_PER_RUN (SAMPLES_PER_RUN)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_sum_valid (w_sum_valid),
        .i_sum_ready (w_sum_ready),
        .o_sums      (w_sums)
    );

    // Stage 2: reciprocal multiply to the floor means
    arbc_div #(
        .SAMPLES_PER_RUN (SAMPLES_PER_RUN)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sum_valid  (w_sum_valid),
        .o_sum_ready  (w_sum_ready),
        .i_sums       (w_sums),
        .o_mean_valid (w_mean_valid),
        .i_mean_ready (w_mean_ready),
        .o_means      (w_means)
    );

    // Stage 3: priority box match and result register
    arbc_match #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mean_valid (w_mean_valid),
        .o_mean_ready (w_mean_ready),
        .i_means      (w_means),
        .i_boxes      (r_box),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

/* rtl/core/arbc_accum.sv */
// Per-channel run accumulators and the register that holds a finished run's sums.
module arbc_accum #(
    parameter int unsigned SAMPLES_PER_RUN = arbc_pkg::SAMPLES_PER_RUN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  arbc_pkg::t_in_item i_in_item,
    output logic               o_sum_valid,
    input  logic               i_sum_ready,
    output arbc_pkg::t_sums    o_sums
);
    import arbc_pkg::*;

    localparam int unsigned CNT_W = (SAMPLES_PER_RUN > 1) ? $clog2(SAMPLES_PER_RUN) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_RUN - 1);

    logic [CNT_W-1:0] r_cnt;
    t_sums            r_acc;
    t_sums            n_acc;
    logic             r_sum_vld;
    t_sums            r_sums;
    logic             w_take;
    logic             w_last;
    logic             w_free;

    assign w_last     = (r_cnt == CNT_LAST);
    assign w_free     = !r_sum_vld || i_sum_ready;
    // Only the item that closes a run needs room downstream
    assign o_in_ready = w_free || !w_last;
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        n_acc.red   = r_acc.red   + SUM_W'(i_in_item.red_period);
        n_acc.green = r_acc.green + SUM_W'(i_in_item.green_period);
        n_acc.blue  = r_acc.blue  + SUM_W'(i_in_item.blue_period);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_acc     <= '0;
            r_sum_vld <= 1'b0;
        end else begin
            if (w_take) begin
                if (w_last) begin
                    r_cnt <= '0;
                    r_acc <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_acc <= n_acc;
                end
            end
            if (w_take && w_last) begin
                r_sum_vld <= 1'b1;
            end else if (i_sum_ready) begin
                r_sum_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_last) begin
            r_sums <= n_acc;
        end
    end

    assign o_sum_valid = r_sum_vld;
    assign o_sums      = r_sums;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("run counter passed the last sample");

    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_acc == '0))
        else $error("accumulators not clear at start of run");

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_vld && !i_sum_ready) |=> (r_sum_vld && $stable(r_sums)))
        else $error("finished sums changed while stalled");
`endif

endmodule

/* rtl/core/arbc_div.sv */
// Floor division of the run sums by the run length through a constant reciprocal.
module arbc_div #(
    parameter int unsigned SAMPLES_PER_RUN = arbc_pkg::SAMPLES_PER_RUN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_sum_valid,
    output logic             o_sum_ready,
    input  arbc_pkg::t_sums  i_sums,
    output logic             o_mean_valid,
    input  logic             i_mean_ready,
    output arbc_pkg::t_means o_means
);
    import arbc_pkg::*;

    localparam int unsigned RECIP_W = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + SAMPLES_PER_RUN - 1) / SAMPLES_PER_RUN);
    localparam int unsigned PROD_W = SUM_W + RECIP_W;
    localparam int unsigned CHK_W  = SUM_W + 1;

    logic [PROD_W-1:0] w_prod_r;
    logic [PROD_W-1:0] w_prod_g;
    logic [PROD_W-1:0] w_prod_b;
    logic              w_load;
    logic              r_vld;
    t_means            r_means;

    // floor(s / N) == (s * ceil(2^k / N)) >> k for every s below 2^SUM_W
    assign w_prod_r = PROD_W'(i_sums.red)   * PROD_W'(RECIP);
    assign w_prod_g = PROD_W'(i_sums.green) * PROD_W'(RECIP);
    assign w_prod_b = PROD_W'(i_sums.blue)  * PROD_W'(RECIP);

    assign o_sum_ready = !r_vld || i_mean_ready;
    assign w_load      = i_sum_valid && o_sum_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_sum_ready) begin
            r_vld <= i_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_means.red   <= w_prod_r[RECIP_SHIFT +: PERIOD_W];
            r_means.green <= w_prod_g[RECIP_SHIFT +: PERIOD_W];
            r_means.blue  <= w_prod_b[RECIP_SHIFT +: PERIOD_W];
        end
    end

    assign o_mean_valid = r_vld;
    assign o_means      = r_means;

`ifndef NO_ASSERTIONS
    a_red_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_load) |->
            ((CHK_W'(r_means.red) * CHK_W'(SAMPLES_PER_RUN) <= CHK_W'($past(i_sums.red)))
            && (CHK_W'($past(i_sums.red))
                < (CHK_W'(r_means.red) + 1'b1) * CHK_W'(SAMPLES_PER_RUN))))
        else $error("red mean is not the floor quotient");
`endif

endmodule

/* rtl/core/arbc_match.sv */
// Priority box match of the three means and the result register.
module arbc_match #(
    parameter int unsigned NUM_CLASSES = arbc_pkg::NUM_CLASSES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mean_valid,
    output logic                o_mean_ready,
    input  arbc_pkg::t_means    i_means,
    input  arbc_pkg::t_box      i_boxes [NUM_CLASSES],
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output arbc_pkg::t_out_item o_out_item
);
    import arbc_pkg::*;

    logic [NUM_CLASSES-1:0] w_hit;
    logic [CODE_W-1:0]      n_code;
    logic                   w_load;
    logic                   r_out_vld;
    t_out_item              r_item;

    function automatic logic box_hit(input t_means m, input t_box b);
        logic hit_r;
        logic hit_g;
        logic hit_b;
        hit_r = (m.red   >= PERIOD_W'(b[7:0]))   && (m.red   <= PERIOD_W'(b[15:8]));
        hit_g = (m.green >= PERIOD_W'(b[23:16])) && (m.green <= PERIOD_W'(b[31:24]));
        hit_b = (m.blue  >= PERIOD_W'(b[39:32])) && (m.blue  <= PERIOD_W'(b[47:40]));
        return hit_r && hit_g && hit_b;
    endfunction

    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            w_hit[i] = box_hit(i_means, i_boxes[i]);
        end
    end

    // Lowest class wins: scan from the top so earlier classes overwrite
    always_comb begin
        n_code = CODE_NO_MATCH;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                n_code = CODE_W'(i);
            end
        end
    end

    assign o_mean_ready = !r_out_vld || i_out_ready;
    assign w_load       = i_mean_valid && o_mean_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_mean_ready) begin
            r_out_vld <= i_mean_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.class_code <= n_code;
            r_item.red_mean   <= i_means.red;
            r_item.green_mean <= i_means.green;
            r_item.blue_mean  <= i_means.blue;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_item;

`ifndef NO_ASSERTIONS
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.class_code == CODE_NO_MATCH)
                         || (o_out_item.class_code < CODE_W'(NUM_CLASSES))))
        else $error("class code outside the configured classes");

    a_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_load) |->
            ((o_out_item.class_code == CODE_NO_MATCH) == ($past(w_hit) == '0)))
        else $error("no-match code disagrees with box hits");
`endif

endmodule

/* tb/arbc_result_checker.sv */
// Result checker for the averaged RGB box classifier: mirrors run sums and class boxes.
module arbc_result_checker #(
    parameter int unsigned SAMPLES_PER_RUN = arbc_pkg::SAMPLES_PER_RUN_DEF,
    parameter int unsigned NUM_CLASSES     = arbc_pkg::NUM_CLASSES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  arbc_pkg::t_in_item             i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  arbc_pkg::t_out_item            i_out_item,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [arbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [arbc_pkg::BOX_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_samples,
    output int                             o_results,
    output logic [arbc_pkg::BOX_COUNT:0]   o_codes_seen
);
    import arbc_pkg::*;

    localparam int unsigned BOX_IDX_W = $clog2(BOX_COUNT);

    logic [SUM_W-1:0]   red_sum   = '0;
    logic [SUM_W-1:0]   green_sum = '0;
    logic [SUM_W-1:0]   blue_sum  = '0;
    int unsigned        run_fill  = 0;
    t_box               class_boxes [BOX_COUNT] = BOX_RESET;
    t_out_item          expected_results [$];
    int                 fail_count = 0;
    int                 samples    = 0;
    int                 results    = 0;
    logic [BOX_COUNT:0] codes_seen = '0;

    function automatic logic in_bounds(input logic [PERIOD_W-1:0] mean,
                                       input logic [7:0] lo, input logic [7:0] hi);
        return (mean >= PERIOD_W'(lo)) && (mean <= PERIOD_W'(hi));
    endfunction

    // First class whose box holds all three means; an inverted box never matches.
    function automatic logic [CODE_W-1:0] classify_means(input t_means m);
        logic [CODE_W-1:0] code;
        t_box              b;
        code = CODE_NO_MATCH;
        for (int k = 0; k < int'(NUM_CLASSES) && k < int'(BOX_COUNT); k++) begin
            b = class_boxes[k];
            if (code == CODE_NO_MATCH && in_bounds(m.red, b[7:0], b[15:8])
                    && in_bounds(m.green, b[23:16], b[31:24])
                    && in_bounds(m.blue, b[39:32], b[47:40])) begin
                code = CODE_W'(k);
            end
        end
        return code;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_means    means;
        t_out_item want;
        if (!i_rst_n) begin
            red_sum     = '0;
            green_sum   = '0;
            blue_sum    = '0;
            run_fill    = 0;
            class_boxes = BOX_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_idx < CFG_IDX_W'(BOX_COUNT)) begin
                class_boxes[i_cfg_idx[BOX_IDX_W-1:0]] = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                results++;
                if (i_out_item.class_code <= CODE_W'(BOX_COUNT)) begin
                    codes_seen[i_out_item.class_code] = 1'b1;
                end
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with nothing expected, got code %0d means %0d/%0d/%0d",
                             $time, i_out_item.class_code, i_out_item.red_mean,
                             i_out_item.green_mean, i_out_item.blue_mean);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("class_code", want.class_code, i_out_item.class_code);
                    check_field("red_mean", want.red_mean, i_out_item.red_mean);
                    check_field("green_mean", want.green_mean, i_out_item.green_mean);
                    check_field("blue_mean", want.blue_mean, i_out_item.blue_mean);
                end
            end
            if (i_in_valid && i_in_ready) begin
                samples++;
                red_sum   = red_sum + i_in_item.red_period;
                green_sum = green_sum + i_in_item.green_period;
                blue_sum  = blue_sum + i_in_item.blue_period;
                run_fill++;
                if (run_fill == SAMPLES_PER_RUN) begin
                    means.red        = PERIOD_W'(red_sum / SUM_W'(SAMPLES_PER_RUN));
                    means.green      = PERIOD_W'(green_sum / SUM_W'(SAMPLES_PER_RUN));
                    means.blue       = PERIOD_W'(blue_sum / SUM_W'(SAMPLES_PER_RUN));
                    want.class_code  = classify_means(means);
                    want.red_mean    = means.red;
                    want.green_mean  = means.green;
                    want.blue_mean   = means.blue;
                    expected_results.push_back(want);
                    red_sum   = '0;
                    green_sum = '0;
                    blue_sum  = '0;
                    run_fill  = 0;
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
        o_samples    <= samples;
        o_results    <= results;
        o_codes_seen <= codes_seen;
    end

endmodule

/* tb/testbench.sv */
// Top of the averaged RGB box classifier testbench: clock, reset, stimulus and verdict.
module testbench;
    import arbc_pkg::*;

    localparam int unsigned RUN_LEN          = SAMPLES_PER_RUN_DEF;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned HOLD_CYCLES      = 250;
    localparam int unsigned CYCLE_LIMIT      = 300000;
    localparam int unsigned RUNS_PER_SETTING = 5;
    localparam int unsigned CORNER_COUNT     = 10;

    // Full byte range on every channel, and min above max on every channel.
    localparam t_box FULL_RANGE_BOX = {3{8'hFF, 8'h00}};
    localparam t_box INVERTED_BOX   = {3{8'h00, 8'hFF}};

    localparam t_cfg_reg BOX_REGS [BOX_COUNT] = '{
        REG_CLASS0_BOX, REG_CLASS1_BOX, REG_CLASS2_BOX, REG_CLASS3_BOX
    };

    typedef enum int {
        SET_RESET, SET_RANDOM, SET_EXTREME, SET_OVERLAP, SET_RESTORE, SET_COUNT
    } t_box_setting;

    typedef enum int {RUN_INSIDE, RUN_EDGE, RUN_EXTREME, RUN_WIDE} t_run_style;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [BOX_W-1:0]     cfg_data  = '0;

    int                   fail_count;
    int                   pending;
    int                   samples_seen;
    int                   results_seen;
    logic [BOX_COUNT:0]   codes_seen;

    // Stimulus-side copy of the boxes, used only to aim runs at them.
    t_box                 box_cfg [BOX_COUNT] = BOX_RESET;
    int unsigned          burst_left  = 0;
    bit                   steady      = 1'b0;
    bit                   hold_req    = 1'b0;
    int unsigned          cycle_count = 0;

    averaged_rgb_box_classifier_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    arbc_result_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_samples   (samples_seen),
        .o_results   (results_seen),
        .o_codes_seen(codes_seen)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: alternate between always-ready stretches, coin-flip stalls and
    // rare stalls. On request, hold ready low so the block backs up and has to
    // stall its input.
    initial begin : receiver
        int unsigned seg_len;
        int unsigned mode;
        forever begin
            if (hold_req) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            seg_len = $urandom_range(10, 120);
            mode    = $urandom_range(0, 2);
            repeat (seg_len) begin
                @(negedge clk);
                if (hold_req) break;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one sample and hold it until accepted. Enter and leave at a falling
    // edge; valid stays high between back-to-back items so it never drops and
    // rises in the same step. Between bursts, insert a random gap.
    task automatic send_sample(input t_in_item item);
        int unsigned gap;
        int unsigned roll;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            roll       = $urandom_range(0, 9);
            if (steady || roll < 4) begin
                gap = 0;
            end else if (roll < 9) begin
                gap = $urandom_range(1, 4);
            end else begin
                gap = $urandom_range(10, 40);
            end
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has drained, then let the
    // pipeline settle so a config write cannot land on work in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register; valid stays high for a following write, the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_box data);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Random box; with inverted set, one channel gets min above max.
    function automatic t_box make_box(input bit inverted);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  tmp;
        t_box        b;
        int unsigned flip;
        b    = '0;
        flip = $urandom_range(0, 2);
        for (int ch = 0; ch < 3; ch++) begin
            lo = 8'($urandom_range(0, 200));
            hi = 8'($urandom_range(int'(lo) + 1, 255));
            if (inverted && ch == int'(flip)) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            b[16*ch +: 8]   = lo;
            b[16*ch+8 +: 8] = hi;
        end
        return b;
    endfunction

    // Corner samples (all-zero, all-ones, alternating bits, one hot channel),
    // then fill the run with full-scale samples so the sums get near the top.
    task automatic send_directed_run();
        t_in_item corner [CORNER_COUNT];
        t_in_item all_high;
        corner = '{
            '{16'h0000, 16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{16'hAAAA, 16'h5555, 16'hAAAA}, '{16'h5555, 16'hAAAA, 16'h5555},
            '{16'hFFFF, 16'h0000, 16'h0000}, '{16'h0000, 16'hFFFF, 16'h0000},
            '{16'h0000, 16'h0000, 16'hFFFF}, '{16'h00FF, 16'hFF00, 16'h0100},
            '{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF}
        };
        all_high = '1;
        foreach (corner[k]) send_sample(corner[k]);
        repeat (RUN_LEN - CORNER_COUNT) send_sample(all_high);
    endtask

    // One full run. Aim each channel's mean at a target: inside a box, on or
    // just past an edge, or at a range extreme. Samples come in +d/-d pairs so
    // the mean holds, and the closing sample adds a remainder below the run
    // length to exercise the floor. Wide runs are plain random samples.
    task automatic send_run(input t_run_style style);
        int       target [3];
        int       delta  [3];
        int       value  [3];
        int       lim;
        int       lo;
        int       hi;
        int       spread;
        int       wide_max;
        t_box     b;
        t_in_item item;
        b        = box_cfg[$urandom_range(0, BOX_COUNT - 1)];
        spread   = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8) : $urandom_range(0, 400);
        wide_max = ($urandom_range(0, 1) != 0) ? 65535 : 511;
        for (int ch = 0; ch < 3; ch++) begin
            lo = int'(b[16*ch +: 8]);
            hi = int'(b[16*ch+8 +: 8]);
            delta[ch] = 0;
            case (style)
                RUN_INSIDE: begin
                    target[ch] = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(0, 255);
                end
                RUN_EDGE: begin
                    case ($urandom_range(0, 3))
                        0:       target[ch] = lo;
                        1:       target[ch] = hi;
                        2:       target[ch] = (lo > 0) ? lo - 1 : 0;
                        default: target[ch] = hi + 1;
                    endcase
                end
                RUN_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       target[ch] = 0;
                        1:       target[ch] = 255;
                        2:       target[ch] = 256;
                        default: target[ch] = 65535;
                    endcase
                end
                default: target[ch] = 0;
            endcase
        end
        for (int j = 0; j < int'(RUN_LEN); j++) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (style == RUN_WIDE) begin
                    value[ch] = $urandom_range(0, wide_max);
                end else if (j % 2 == 0) begin
                    lim = spread;
                    if (target[ch] < lim) lim = target[ch];
                    if (65535 - target[ch] < lim) lim = 65535 - target[ch];
                    delta[ch] = $urandom_range(0, lim);
                    value[ch] = target[ch] + delta[ch];
                end else begin
                    value[ch] = target[ch] - delta[ch];
                    if (j == int'(RUN_LEN) - 1) begin
                        lim = 65535 - value[ch];
                        if (lim > int'(RUN_LEN) - 1) lim = int'(RUN_LEN) - 1;
                        value[ch] = value[ch] + $urandom_range(0, lim);
                    end
                end
            end
            item.red_period   = PERIOD_W'(value[0]);
            item.green_period = PERIOD_W'(value[1]);
            item.blue_period  = PERIOD_W'(value[2]);
            send_sample(item);
        end
    endtask

    // Main sequence: one pass per box setting. Rewrite the boxes only once the
    // block has drained, including a write to an unused index that must be
    // dropped, then send a mix of aimed and random runs.
    initial begin : stimulus
        t_box        next_boxes [BOX_COUNT];
        int unsigned first;
        int unsigned inv_k;
        int unsigned roll;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int s = SET_RESET; s < SET_COUNT; s++) begin
            if (t_box_setting'(s) == SET_RESET) begin
                send_directed_run();
            end else begin
                // Pause the sender until every result is back.
                wait_idle();
                case (t_box_setting'(s))
                    SET_RANDOM: begin
                        inv_k = $urandom_range(0, BOX_COUNT - 1);
                        foreach (next_boxes[k]) next_boxes[k] = make_box(k == int'(inv_k));
                    end
                    SET_EXTREME: begin
                        next_boxes[0] = '0;
                        next_boxes[1] = '1;
                        next_boxes[2] = INVERTED_BOX;
                        next_boxes[3] = FULL_RANGE_BOX;
                    end
                    SET_OVERLAP: begin
                        // Later boxes copy box 0, are full-range or random; first wins.
                        next_boxes[0] = make_box(1'b0);
                        for (int k = 1; k < int'(BOX_COUNT); k++) begin
                            case ($urandom_range(0, 2))
                                0:       next_boxes[k] = next_boxes[0];
                                1:       next_boxes[k] = FULL_RANGE_BOX;
                                default: next_boxes[k] = make_box(1'b0);
                            endcase
                        end
                    end
                    default: next_boxes = BOX_RESET;
                endcase
                first = $urandom_range(0, BOX_COUNT - 1);
                for (int k = 0; k < int'(BOX_COUNT); k++) begin
                    write_reg(BOX_REGS[(int'(first) + k) % BOX_COUNT],
                              next_boxes[(int'(first) + k) % BOX_COUNT]);
                end
                write_reg(CFG_IDX_W'(BOX_COUNT + $urandom_range(0, (1 << CFG_IDX_W) - 1 - BOX_COUNT)),
                          BOX_W'({$urandom, $urandom}));
                cfg_valid <= 1'b0;
                box_cfg = next_boxes;
            end
            if (t_box_setting'(s) == SET_EXTREME) begin
                // Stream without gaps while the receiver holds off; the fourth
                // closing item finds all three stages full and must stall.
                hold_req = 1'b1;
                steady   = 1'b1;
                repeat (4) send_run(RUN_INSIDE);
                steady   = 1'b0;
            end
            repeat (RUNS_PER_SETTING) begin
                roll = $urandom_range(0, 9);
                if (roll < 5) begin
                    send_run(RUN_INSIDE);
                end else if (roll < 7) begin
                    send_run(RUN_EDGE);
                end else if (roll < 8) begin
                    send_run(RUN_EXTREME);
                end else begin
                    send_run(RUN_WIDE);
                end
            end
        end
        wait_idle();
        $display("Covered %0d samples and %0d result items across %0d box settings",
                 samples_seen, results_seen, int'(SET_COUNT));
        $display("Class codes seen, one bit per code from 0 up: %b; one long receiver hold-off",
                 codes_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
